/* hdl/imuafp_pkg.sv */
// Package for the IMU angle frame parser.
// Byte type, frame slot numbering and protocol constants; no dependencies.
package imuafp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] slot_t;

  localparam byte_t SYNC_BYTE        = 8'h55;
  localparam byte_t ANGLE_TYPE_RESET = 8'd83;

  // slot_t values: which frame byte the parser expects next
  localparam slot_t SLOT_HUNT  = 4'd0;
  localparam slot_t SLOT_TYPE  = 4'd1;
  localparam slot_t SLOT_CHECK = 4'd10;

  localparam int unsigned PAYLOAD_LEN = 8;

endpackage

/* hdl/imuafp_byte_cell.sv */
// One payload cell of the IMU angle frame parser's byte chain.
// Holds one byte and loads its left neighbor's byte on a shift. Uses imuafp_pkg.
module imuafp_byte_cell
  import imuafp_pkg::*;
(
  input  logic  clk,
  input  logic  shift_en,
  input  byte_t din,
  output byte_t dout
);

  byte_t data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

/* hdl/imu_angle_frame_parser.sv */
// Top level of the IMU angle frame parser: sync hunt, checksum, type match.
// Uses imuafp_pkg and a chain of imuafp_byte_cell instances for the payload.
//
//  channel | ports                                   | dir | transfer when
//  --------+-----------------------------------------+-----+----------------------
//  in      | in_valid, in_ready, in_rx_byte          | in  | in_valid & in_ready
//  out     | out_valid, out_ready, out_roll_code,    | out | out_valid & out_ready
//          | out_pitch_code, out_yaw_code,           |     |
//          | out_fw_version                          |     |
//  cfg     | cfg_valid, cfg_ready, cfg_angle_type_code| in | cfg_valid & cfg_ready
//
// One byte is taken per cycle while in_ready is high; a result shows on the output
// register the cycle after the check byte's transfer. The payload bytes run through
// an 8-cell shift chain, so the frame needs no addressed storage.
// in_ready drops only when the check byte is next and the output register is
// still full and not being drained; any other byte is taken regardless of out.
// Synchronous active-low reset puts the parser in sync hunt, clears the output
// valid and loads the angle type code with 0x53. Payload cells are not reset.
module imu_angle_frame_parser
  import imuafp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_roll_code,
  output logic signed [15:0] out_pitch_code,
  output logic signed [15:0] out_yaw_code,
  output logic [15:0] out_fw_version,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_angle_type_code
);

  // frame tracking state
  slot_t slot_r, slot_nxt;
  byte_t sum_r, sum_nxt;
  byte_t type_r, type_nxt;
  byte_t angle_code_r;

  // output register
  logic  out_valid_r, out_valid_nxt;
  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic [15:0] ver_r;

  logic  in_fire;
  logic  shift_en;
  logic  frame_good;
  byte_t chain [PAYLOAD_LEN];

  assign cfg_ready = 1'b1;
  // only a check byte can produce a result, so only it waits on the out slot
  assign in_ready  = (slot_r != SLOT_CHECK) || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    slot_nxt   = slot_r;
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    shift_en   = 1'b0;
    frame_good = 1'b0;
    if (in_fire) begin
      case (slot_r)
        SLOT_HUNT: begin
          if (in_rx_byte == SYNC_BYTE) begin
            sum_nxt  = SYNC_BYTE;
            slot_nxt = SLOT_TYPE;
          end
        end
        SLOT_TYPE: begin
          type_nxt = in_rx_byte;
          sum_nxt  = sum_r + in_rx_byte;
          slot_nxt = slot_r + 4'd1;
        end
        default: begin
          if (slot_r < SLOT_CHECK) begin
            // payload byte: no resync on a sync value here
            shift_en = 1'b1;
            sum_nxt  = sum_r + in_rx_byte;
            slot_nxt = slot_r + 4'd1;
          end else begin
            frame_good = (slot_r == SLOT_CHECK) && (in_rx_byte == sum_r) &&
                         (type_r == angle_code_r);
            slot_nxt   = SLOT_HUNT;
          end
        end
      endcase
    end
  end

  // Payload shift chain: first byte in ends up in the last cell.
  genvar gi;
  generate
    for (gi = 0; gi < PAYLOAD_LEN; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        imuafp_byte_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .din      (in_rx_byte),
          .dout     (chain[gi])
        );
      end else begin : g_body
        imuafp_byte_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .din      (chain[gi-1]),
          .dout     (chain[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_good) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= SLOT_HUNT;
      sum_r        <= '0;
      type_r       <= '0;
      angle_code_r <= ANGLE_TYPE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      type_r      <= type_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        angle_code_r <= cfg_angle_type_code;
      end
    end
  end

  // little-endian words; payload byte 0 sits in the last cell
  always_ff @(posedge clk) begin
    if (frame_good) begin
      roll_r  <= {chain[6], chain[7]};
      pitch_r <= {chain[4], chain[5]};
      yaw_r   <= {chain[2], chain[3]};
      ver_r   <= {chain[0], chain[1]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_roll_code  = roll_r;
  assign out_pitch_code = pitch_r;
  assign out_yaw_code   = yaw_r;
  assign out_fw_version = ver_r;

`ifndef SYNTHESIS
  a_good_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    frame_good |=> out_valid_r)
    else $error("good frame did not load output register");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_CHECK)
    else $error("frame slot out of range");

  a_hunt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (slot_r == SLOT_HUNT) && (in_rx_byte != SYNC_BYTE)) |=>
      (slot_r == SLOT_HUNT))
    else $error("left hunt without sync byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frame_good |-> (!out_valid_r || out_ready))
    else $error("result would overwrite pending output");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for imu_angle_frame_parser.
// Uses imuafp_pkg for byte and slot types and the protocol constants.
module tb;
  import imuafp_pkg::*;

  // first payload slot follows the type byte
  localparam slot_t SLOT_PAYLOAD0 = SLOT_TYPE + 4'd1;
  // idle cycles after the last result before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TIMEOUT_UNITS = 400000;
  localparam int unsigned GAP_MAX = 14;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [15:0]        fw;
  } angle_rec_t;

  // Tracks the frame parser byte by byte and holds the angle results that
  // good frames of the configured type should produce, oldest first.
  class angle_scoreboard;
    byte_t      angle_code;
    slot_t      slot;
    byte_t      sum;
    byte_t      frame_type;
    byte_t      payload [PAYLOAD_LEN];
    angle_rec_t angles_due [$];
    int unsigned errors;

    function new();
      angle_code = ANGLE_TYPE_RESET;
      slot       = SLOT_HUNT;
      sum        = '0;
      frame_type = '0;
      errors     = 0;
    endfunction

    // one accepted input byte
    function void note_byte(byte_t b);
      angle_rec_t rec;
      if (slot == SLOT_HUNT) begin
        if (b == SYNC_BYTE) begin
          sum  = SYNC_BYTE;
          slot = SLOT_TYPE;
        end
      end else if (slot == SLOT_TYPE) begin
        frame_type = b;
        sum        = sum + b;
        slot       = SLOT_PAYLOAD0;
      end else if (slot < SLOT_CHECK) begin
        payload[slot - SLOT_PAYLOAD0] = b;
        sum  = sum + b;
        slot = slot + 4'd1;
      end else begin
        if (slot == SLOT_CHECK && b == sum && frame_type == angle_code) begin
          rec.roll  = {payload[1], payload[0]};
          rec.pitch = {payload[3], payload[2]};
          rec.yaw   = {payload[5], payload[4]};
          rec.fw    = {payload[7], payload[6]};
          angles_due.push_back(rec);
        end
        slot = SLOT_HUNT;
      end
    endfunction

    // one accepted output result
    function void check_result(angle_rec_t got);
      angle_rec_t want;
      if (angles_due.size() == 0) begin
        $error("unexpected result: roll %0d pitch %0d yaw %0d fw %0d",
               got.roll, got.pitch, got.yaw, got.fw);
        errors++;
        return;
      end
      want = angles_due.pop_front();
      if (got.roll !== want.roll) begin
        $error("roll_code: expected %0d, got %0d", want.roll, got.roll);
        errors++;
      end
      if (got.pitch !== want.pitch) begin
        $error("pitch_code: expected %0d, got %0d", want.pitch, got.pitch);
        errors++;
      end
      if (got.yaw !== want.yaw) begin
        $error("yaw_code: expected %0d, got %0d", want.yaw, got.yaw);
        errors++;
      end
      if (got.fw !== want.fw) begin
        $error("fw_version: expected %0d, got %0d", want.fw, got.fw);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  byte_t              in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_roll_code;
  logic signed [15:0] out_pitch_code;
  logic signed [15:0] out_yaw_code;
  logic [15:0]        out_fw_version;
  logic               cfg_valid;
  logic               cfg_ready;
  byte_t              cfg_angle_type_code;

  angle_scoreboard sb = new();

  bit          calm;        // no idling on either side once set
  int unsigned gap_pct;     // sender idle odds, redrawn per frame
  int unsigned sent_bytes;  // accepted input transfers

  imu_angle_frame_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_roll_code       (out_roll_code),
    .out_pitch_code      (out_pitch_code),
    .out_yaw_code        (out_yaw_code),
    .out_fw_version      (out_fw_version),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_angle_type_code (cfg_angle_type_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a transfer or a result never shows up.
  initial begin
    #(TIMEOUT_UNITS);
    $display("Verification failed");
    $finish;
  end

  // Result side: ready toggles in bursts; one NBA per time step.
  initial begin : out_ready_gen
    int unsigned hold;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, GAP_MAX);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 24);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Sample the result transfer with pre-edge values.
  always @(posedge clk) begin
    angle_rec_t got;
    if (rst_n && out_valid && out_ready) begin
      got.roll  = out_roll_code;
      got.pitch = out_pitch_code;
      got.yaw   = out_yaw_code;
      got.fw    = out_fw_version;
      sb.check_result(got);
    end
  end

  // One input transfer. Valid is left high on return so back-to-back bytes
  // never drop it; the caller lowers it when it wants to idle.
  task automatic send_byte(input byte_t b);
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  // Sync, type, eight payload bytes (byte 0 in pl[7:0]), then the check byte.
  // A corrupt frame gets a check byte that is off by a nonzero xor.
  task automatic send_frame(input byte_t ftype, input logic [63:0] pl, input bit corrupt);
    byte_t chk;
    chk = SYNC_BYTE + ftype;
    for (int i = 0; i < PAYLOAD_LEN; i++) chk = chk + pl[8*i +: 8];
    if (corrupt) chk = chk ^ byte_t'($urandom_range(1, 255));
    send_byte(SYNC_BYTE);
    send_byte(ftype);
    for (int i = 0; i < PAYLOAD_LEN; i++) send_byte(pl[8*i +: 8]);
    send_byte(chk);
  endtask

  // Sender holds off until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.angles_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write only with the parser hunting and the output empty.
  task automatic write_angle_code(input byte_t code);
    while (sb.slot != SLOT_HUNT) send_byte(8'h00);
    drain_results();
    cfg_valid           <= 1'b1;
    cfg_angle_type_code <= code;
    do @(posedge clk); while (!cfg_ready);
    sb.angle_code = code;
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_t edge_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'h7F;
      3:       return 8'hFF;
      default: return SYNC_BYTE;
    endcase
  endfunction

  // Mostly well-formed angle frames with random content; the rest are
  // wrong-type frames, bad check bytes and loose noise (which may hold a
  // stray sync and so start a bogus frame).
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned kind;
    logic [63:0] pl;
    byte_t       ftype;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      case ($urandom_range(0, 3))
        0, 1:    gap_pct = 0;
        2:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      kind = $urandom_range(0, 9);
      pl   = {$urandom, $urandom};
      for (int i = 0; i < PAYLOAD_LEN; i++)
        if ($urandom_range(0, 5) == 0) pl[8*i +: 8] = edge_byte();
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom));
      end else if (kind == 1) begin
        ftype = sb.angle_code ^ byte_t'($urandom_range(1, 255));
        send_frame(ftype, pl, 1'b0);
      end else if (kind == 2) begin
        send_frame(sb.angle_code, pl, 1'b1);
      end else begin
        send_frame(sb.angle_code, pl, 1'b0);
      end
      if (!calm && $urandom_range(0, 24) == 0) drain_results();
    end
  endtask

  initial begin
    in_valid            <= 1'b0;
    in_rx_byte          <= '0;
    cfg_valid           <= 1'b0;
    cfg_angle_type_code <= '0;
    rst_n               <= 1'b0;
    calm       = 1'b0;
    gap_pct    = 0;
    sent_bytes = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at the reset type code.
    // Noise while hunting.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    // Good frame: roll at the negative end, pitch at the positive end, yaw
    // made of sync values inside the frame, version all ones.
    send_frame(ANGLE_TYPE_RESET, 64'hFFFF_5555_7FFF_8000, 1'b0);
    // Bad check byte, then a frame of another type; neither gives a result.
    send_frame(ANGLE_TYPE_RESET, 64'h0123_4567_89AB_CDEF, 1'b1);
    send_frame(ANGLE_TYPE_RESET + 8'd1, 64'h0000_0000_0000_0000, 1'b0);
    // Good frame with all-zero payload.
    send_frame(ANGLE_TYPE_RESET, 64'h0000_0000_0000_0000, 1'b0);

    // Random phases over several type codes, the extremes among them.
    random_traffic(70);
    write_angle_code(8'h00);
    random_traffic(55);
    write_angle_code(8'hFF);
    random_traffic(55);
    write_angle_code(SYNC_BYTE);
    random_traffic(50);
    write_angle_code(byte_t'($urandom));
    random_traffic(50);

    // Last part without idling on either side.
    calm = 1'b1;
    write_angle_code(ANGLE_TYPE_RESET);
    random_traffic(60);

    drain_results();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
